[rtl/rotation_matrix_to_quaternion_macros.svh]
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMQ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; imported by every module of the block.
package rmq_pkg;

   localparam int ELEM_W     = 16;  // element and component width
   localparam int FRAC_W     = 14;  // fraction bits
   localparam int THR_W      = 15;  // threshold register width
   localparam int D_W        = 19;  // signed radicand before range check
   localparam int RAD_W      = 17;  // positive radicand
   localparam int NUM_W      = 17;  // numerator width (signed sum / magnitude)
   localparam int SQ_IN_W    = 32;  // radicand scaled by 2^FRAC_W, even width
   localparam int ROOT_W     = SQ_IN_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQ_ITER    = 2;   // root bits per stage
   localparam int SQ_STAGES  = ROOT_W / SQ_ITER;
   localparam int S_W        = ROOT_W + 1;  // scale = 2 * root
   localparam int DVD_W      = 32;  // rounded dividend
   localparam int QUO_W      = 18;  // quotient bits produced
   localparam int DIV_ITER   = 3;   // quotient bits per stage
   localparam int DIV_STAGES = QUO_W / DIV_ITER;
   localparam int LANES      = 3;

   localparam logic [1:0] BR_TRACE  = 2'd0;
   localparam logic [1:0] BR_FIRST  = 2'd1;
   localparam logic [1:0] BR_SECOND = 2'd2;
   localparam logic [1:0] BR_THIRD  = 2'd3;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

   typedef struct packed {
      logic signed [ELEM_W-1:0] r0c0;
      logic signed [ELEM_W-1:0] r1c0;
      logic signed [ELEM_W-1:0] r2c0;
      logic signed [ELEM_W-1:0] r0c1;
      logic signed [ELEM_W-1:0] r1c1;
      logic signed [ELEM_W-1:0] r2c1;
      logic signed [ELEM_W-1:0] r0c2;
      logic signed [ELEM_W-1:0] r1c2;
      logic signed [ELEM_W-1:0] r2c2;
   } matrix_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]                  br;
      logic                        degen;
      logic [RAD_W-1:0]            rad;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][NUM_W-1:0] mag;
   } work_item_type;

   typedef struct packed {
      logic [ELEM_W-1:0] x;
      logic [ELEM_W-1:0] y;
      logic [ELEM_W-1:0] z;
      logic [ELEM_W-1:0] w;
      logic [1:0]        br;
      logic              degen;
   } result_type;

endpackage

[rtl/rmq_front.sv]
// Front end: threshold register, branch choice, radicand and numerators.
// Depends on rmq_pkg; feeds rmq_queue.
module rmq_front
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [THR_W-1:0]  csr_data,
   input  logic              push,
   output logic              full,
   input  matrix_type        mat,
   output logic              out_valid,
   input  logic              out_ready,
   output work_item_type     out_item
);

   localparam logic signed [D_W-1:0] ONE = D_W'(2 ** FRAC_W);

   logic [THR_W-1:0]        thr_ff;
   logic                    fv_ff, fv_in;
   work_item_type           item_ff, item_in;
   logic                    take;

   logic signed [D_W-1:0]   e00, e11, e22, d_tr, d_sel;
   logic signed [NUM_W-1:0] p10, p20, p21, m21, m02, m10;
   logic signed [NUM_W-1:0] n [LANES];

   assign csr_ready = 1'b1;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // radicands and branch choice
   always_comb begin
      e00  = D_W'(mat.r0c0);
      e11  = D_W'(mat.r1c1);
      e22  = D_W'(mat.r2c2);
      d_tr = e00 + e11 + e22 + ONE;
      p10  = NUM_W'(mat.r1c0) + NUM_W'(mat.r0c1);
      p20  = NUM_W'(mat.r0c2) + NUM_W'(mat.r2c0);
      p21  = NUM_W'(mat.r2c1) + NUM_W'(mat.r1c2);
      m21  = NUM_W'(mat.r2c1) - NUM_W'(mat.r1c2);
      m02  = NUM_W'(mat.r0c2) - NUM_W'(mat.r2c0);
      m10  = NUM_W'(mat.r1c0) - NUM_W'(mat.r0c1);
      if (d_tr > $signed({{(D_W-THR_W){1'b0}}, thr_ff})) begin
         item_in.br = BR_TRACE;
         d_sel = d_tr;
         n[0] = m21; n[1] = m02; n[2] = m10;
      end else if (mat.r0c0 > mat.r1c1 && mat.r0c0 > mat.r2c2) begin
         item_in.br = BR_FIRST;
         d_sel = ONE + e00 - e11 - e22;
         n[0] = p10; n[1] = p20; n[2] = m21;
      end else if (mat.r1c1 > mat.r2c2) begin
         item_in.br = BR_SECOND;
         d_sel = ONE + e11 - e00 - e22;
         n[0] = p10; n[1] = p21; n[2] = m02;
      end else begin
         item_in.br = BR_THIRD;
         d_sel = ONE + e22 - e00 - e11;
         n[0] = p20; n[1] = p21; n[2] = m10;
      end
      item_in.degen = (d_sel <= 0);
      item_in.rad   = d_sel[RAD_W-1:0];
      for (int k = 0; k < LANES; k++) begin
         item_in.neg[k] = n[k][NUM_W-1];
         item_in.mag[k] = n[k][NUM_W-1] ? NUM_W'(-n[k]) : NUM_W'(n[k]);
      end
   end

   // front register, advances when empty or when the queue takes it
   assign take  = !fv_ff || out_ready;
   assign full  = !take;
   assign fv_in = take ? push : fv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = fv_ff;
   assign out_item  = item_ff;

endmodule

[rtl/rmq_queue.sv]
// Two-entry queue between the front end and the arithmetic back end.
// Depends on rmq_pkg for the work item type.
module rmq_queue
   import rmq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  work_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output work_item_type out_item
);

   work_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign wr        = in_valid && in_ready;
   assign rd        = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/rmq_back.sv]
// Back end: pipelined square root, three pipelined dividers, saturation
// and component placement. Depends on rmq_pkg; fed by rmq_queue.
module rmq_back
   import rmq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  work_item_type in_item,
   output logic          out_valid,
   input  logic          out_pop,
   output result_type    out_res
);

   typedef struct packed {
      logic [1:0]                  br;
      logic                        degen;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][NUM_W-1:0] mag;
      logic [SQ_IN_W-1:0]          rad;
      logic [ROOT_W-1:0]           root;
      logic [REM_W-1:0]            rem;
   } sq_type;

   typedef struct packed {
      logic [1:0]                  br;
      logic                        degen;
      logic [LANES-1:0]            neg;
      logic [S_W-1:0]              s;
      logic [LANES-1:0]            ovf;
      logic [LANES-1:0][S_W-1:0]   rem;
      logic [LANES-1:0][QUO_W-1:0] dvd;
      logic [LANES-1:0][QUO_W-1:0] quo;
   } dv_type;

   localparam logic [QUO_W-1:0] MAX_POS = QUO_W'(2 ** (ELEM_W - 1) - 1);
   localparam logic [QUO_W-1:0] MAX_NEG = QUO_W'(2 ** (ELEM_W - 1));

   // one root bit: bring down two radicand bits, try 4*root+1
   function automatic sq_type sq_step(sq_type a);
      sq_type           r;
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      r     = a;
      cur   = {a.rem, a.rad[SQ_IN_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, a.root, 2'b01};
      r.rad = a.rad << 2;
      if (cur >= trial) begin
         r.rem  = REM_W'(cur - trial);
         r.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur[REM_W-1:0];
         r.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // one quotient bit in each lane, restoring
   function automatic dv_type dv_step(dv_type a);
      dv_type       r;
      logic [S_W:0] cur;
      r = a;
      for (int k = 0; k < LANES; k++) begin
         cur      = {a.rem[k], a.dvd[k][QUO_W-1]};
         r.dvd[k] = a.dvd[k] << 1;
         if (cur >= {1'b0, a.s}) begin
            r.rem[k] = S_W'(cur - {1'b0, a.s});
            r.quo[k] = {a.quo[k][QUO_W-2:0], 1'b1};
         end else begin
            r.rem[k] = cur[S_W-1:0];
            r.quo[k] = {a.quo[k][QUO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic sq_type sq_load(work_item_type w);
      sq_type r;
      r.br    = w.br;
      r.degen = w.degen;
      r.neg   = w.neg;
      r.mag   = w.mag;
      r.rad   = SQ_IN_W'({w.rad, {FRAC_W{1'b0}}});
      r.root  = '0;
      r.rem   = '0;
      return r;
   endfunction

   // scale, rounded dividend, quotient overflow check
   function automatic dv_type dv_load(sq_type a);
      dv_type           r;
      logic [DVD_W-1:0] nn;
      r.br    = a.br;
      r.degen = a.degen;
      r.neg   = a.neg;
      r.s     = {a.root, 1'b0};
      r.quo   = '0;
      for (int k = 0; k < LANES; k++) begin
         nn = DVD_W'({a.mag[k], {FRAC_W{1'b0}}}) + DVD_W'(a.root);
         r.ovf[k] = S_W'(nn[DVD_W-1:QUO_W]) >= r.s;
         r.rem[k] = S_W'(nn[DVD_W-1:QUO_W]);
         r.dvd[k] = nn[QUO_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [ELEM_W-1:0] lane_sat(logic neg, logic ovf,
                                                  logic [QUO_W-1:0] q);
      logic [ELEM_W-1:0] v;
      if (!neg) begin
         v = (ovf || q > MAX_POS) ? MAX_POS[ELEM_W-1:0] : q[ELEM_W-1:0];
      end else begin
         v = (ovf || q > MAX_NEG) ? MAX_NEG[ELEM_W-1:0] : ELEM_W'(-q[ELEM_W-1:0]);
      end
      return v;
   endfunction

   function automatic result_type finish(dv_type a);
      result_type        r;
      logic [ELEM_W-1:0] l0, l1, l2, big;
      logic [S_W:0]      sp;
      l0  = lane_sat(a.neg[0], a.ovf[0], a.quo[0]);
      l1  = lane_sat(a.neg[1], a.ovf[1], a.quo[1]);
      l2  = lane_sat(a.neg[2], a.ovf[2], a.quo[2]);
      sp  = {1'b0, a.s} + (S_W+1)'(2);
      big = ELEM_W'(sp >> 2);
      r.br    = a.br;
      r.degen = a.degen;
      case (a.br)
         BR_TRACE:  begin r.x = l0;  r.y = l1;  r.z = l2;  r.w = big; end
         BR_FIRST:  begin r.x = big; r.y = l0;  r.z = l1;  r.w = l2;  end
         BR_SECOND: begin r.x = l0;  r.y = big; r.z = l1;  r.w = l2;  end
         default:   begin r.x = l0;  r.y = l1;  r.z = big; r.w = l2;  end
      endcase
      if (a.degen) begin
         r.x = '0; r.y = '0; r.z = '0; r.w = '0;
      end
      return r;
   endfunction

   sq_type              sq_ff [SQ_STAGES];
   sq_type              sq_in [SQ_STAGES];
   logic [SQ_STAGES-1:0] sq_v_ff;
   dv_type              dv_ff [DIV_STAGES+1];
   dv_type              dv_in [DIV_STAGES+1];
   logic [DIV_STAGES:0] dv_v_ff;
   result_type          out_ff, out_in;
   logic                out_v_ff;
   logic                adv;

   // whole pipeline moves unless the result register is held
   assign adv       = !out_v_ff || out_pop;
   assign in_ready  = adv;
   assign out_valid = out_v_ff;
   assign out_res   = out_ff;

   // stage logic
   always_comb begin
      sq_type t;
      dv_type u;
      t = sq_load(in_item);
      for (int j = 0; j < SQ_ITER; j++) t = sq_step(t);
      sq_in[0] = t;
      for (int i = 1; i < SQ_STAGES; i++) begin
         t = sq_ff[i-1];
         for (int j = 0; j < SQ_ITER; j++) t = sq_step(t);
         sq_in[i] = t;
      end
      dv_in[0] = dv_load(sq_ff[SQ_STAGES-1]);
      for (int i = 1; i <= DIV_STAGES; i++) begin
         u = dv_ff[i-1];
         for (int j = 0; j < DIV_ITER; j++) u = dv_step(u);
         dv_in[i] = u;
      end
      out_in = finish(dv_ff[DIV_STAGES]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= '0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         sq_v_ff  <= {sq_v_ff[SQ_STAGES-2:0], in_valid};
         dv_v_ff  <= {dv_v_ff[DIV_STAGES-1:0], sq_v_ff[SQ_STAGES-1]};
         out_v_ff <= dv_v_ff[DIV_STAGES];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < SQ_STAGES; i++) sq_ff[i] <= sq_in[i];
         for (int i = 0; i <= DIV_STAGES; i++) dv_ff[i] <= dv_in[i];
         out_ff <= out_in;
      end
   end

endmodule

[rtl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to quaternion (Shepperd), Q2.14 in and out.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back and the macro header.
//
//   channel   handshake          payload
//   req       push / full        req_r0c0 .. req_r2c2
//   rsp       empty / pop        rsp_quat_x/y/z/w, rsp_branch_taken, rsp_degenerate
//   csr       csr_valid / ready  csr_trace_threshold
//
// One matrix per cycle sustained while the result is not held; after the
// transfer edge an item passes the front register, the queue, 8 square-root
// stages of 2 bits, setup, 6 divider stages of 3 bits and the result register.
// Synchronous active-high reset empties all stages and sets the threshold to 2.
// A held result stalls the back end; the queue and front register then fill,
// holding up to three items, before full rises.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic signed [ELEM_W-1:0] req_r0c0,
   input  logic signed [ELEM_W-1:0] req_r1c0,
   input  logic signed [ELEM_W-1:0] req_r2c0,
   input  logic signed [ELEM_W-1:0] req_r0c1,
   input  logic signed [ELEM_W-1:0] req_r1c1,
   input  logic signed [ELEM_W-1:0] req_r2c1,
   input  logic signed [ELEM_W-1:0] req_r0c2,
   input  logic signed [ELEM_W-1:0] req_r1c2,
   input  logic signed [ELEM_W-1:0] req_r2c2,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [ELEM_W-1:0] rsp_quat_x,
   output logic signed [ELEM_W-1:0] rsp_quat_y,
   output logic signed [ELEM_W-1:0] rsp_quat_z,
   output logic signed [ELEM_W-1:0] rsp_quat_w,
   output logic [1:0]               rsp_branch_taken,
   output logic                     rsp_degenerate,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [THR_W-1:0]         csr_trace_threshold
);

   matrix_type    mat;
   logic          f_valid, f_ready, q_valid, q_ready, b_valid;
   work_item_type f_item, q_item;
   result_type    res;

   assign mat = '{r0c0: req_r0c0, r1c0: req_r1c0, r2c0: req_r2c0,
                  r0c1: req_r0c1, r1c1: req_r1c1, r2c1: req_r2c1,
                  r0c2: req_r0c2, r1c2: req_r1c2, r2c2: req_r2c2};

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_trace_threshold),
      .push      (push),
      .full      (full),
      .mat       (mat),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   rmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   rmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (b_valid),
      .out_pop   (pop),
      .out_res   (res)
   );

   // result ports
   assign empty            = !b_valid;
   assign rsp_quat_x       = res.x;
   assign rsp_quat_y       = res.y;
   assign rsp_quat_z       = res.z;
   assign rsp_quat_w       = res.w;
   assign rsp_branch_taken = res.br;
   assign rsp_degenerate   = res.degen;

   // checks
   `RMQ_ASSERT_IMP(a_degen_zero, !empty && rsp_degenerate,
      rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0 && rsp_quat_w == 0,
      "degenerate result with nonzero component")
   `RMQ_ASSERT_IMP(a_trace_ok, !empty && rsp_branch_taken == BR_TRACE,
      !rsp_degenerate && rsp_quat_w > 0, "trace branch without positive w")
   `RMQ_ASSERT_NXT(a_hold, !empty && !pop, !empty, "waiting result lost")

endmodule
